// ===== rtl/clne_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clne_pkg: shared types and constants
// Request codes, bus constants and queue entry types for the LCD nibble encoder.
// ----------------------------------------------------------------------------
package clne_pkg;

  typedef enum logic [1:0] {
    FUNC_INIT = 2'd0,
    FUNC_PUT  = 2'd1,
    FUNC_GOTO = 2'd2,
    FUNC_RAW  = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    CFG_FUNCTION_SET = 2'd0,
    CFG_DISPLAY_CTRL = 2'd1,
    CFG_ENTRY_MODE   = 2'd2
  } cfg_idx_t;

  localparam logic [7:0] FUNCTION_SET_RST = 8'h20 | (8'h02 << 2);
  localparam logic [7:0] DISPLAY_CTRL_RST = 8'h0C;
  localparam logic [7:0] ENTRY_MODE_RST   = 8'h06;

  // Control characters for put character
  localparam logic [7:0] CHAR_FORMFEED  = 8'h0C;
  localparam logic [7:0] CHAR_NEWLINE   = 8'h0A;
  localparam logic [7:0] CHAR_BACKSPACE = 8'h08;

  // Commands
  localparam logic [7:0] CMD_CLEAR       = 8'h01;
  localparam logic [7:0] CMD_LINE2       = 8'hC0;
  localparam logic [7:0] CMD_CURSOR_LEFT = 8'h10;

  // Set-address bases for rows one to four
  localparam logic [7:0] ROW1_BASE = 8'h80;
  localparam logic [7:0] ROW2_BASE = 8'hC0;
  localparam logic [7:0] ROW3_BASE = 8'h94;
  localparam logic [7:0] ROW4_BASE = 8'hD4;

  // Wake-up nibbles
  localparam logic [3:0] WAKE_NIB  = 4'h3;
  localparam logic [3:0] MODE4_NIB = 4'h2;

  localparam int unsigned INIT_WRITES = 12;
  localparam int unsigned BYTE_WRITES = 2;
  localparam int unsigned STEP_W      = $clog2(INIT_WRITES);
  localparam logic [STEP_W-1:0] INIT_LAST = STEP_W'(INIT_WRITES - 1);
  localparam logic [STEP_W-1:0] BYTE_LAST = STEP_W'(BYTE_WRITES - 1);

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // One classified request: either the init sequence or one byte
  typedef struct packed {
    logic       is_init;
    logic [7:0] data;
    logic       rs;
  } entry_t;

  typedef struct packed {
    logic [7:0] function_set;
    logic [7:0] display_ctrl;
    logic [7:0] entry_mode;
  } cfg_t;

  typedef struct packed {
    logic              head_valid;
    logic [QCNT_W-1:0] count;
  } q_status_t;

  typedef struct packed {
    logic              fire;
    logic              pop;
    logic [STEP_W-1:0] step;
  } back_status_t;

endpackage

// ===== rtl/clne_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clne_front: request classifier
// Maps a request to either the init sequence or one byte plus register select.
// ----------------------------------------------------------------------------
module clne_front (
  input  logic [1:0]      in_func,
  input  logic [7:0]      in_char_code,
  input  logic [5:0]      in_column,
  input  logic [2:0]      in_row,
  output clne_pkg::entry_t entry
);

  logic [7:0] base;

  always_comb begin
    unique case (in_row)
      3'd2:    base = clne_pkg::ROW2_BASE;
      3'd3:    base = clne_pkg::ROW3_BASE;
      3'd4:    base = clne_pkg::ROW4_BASE;
      default: base = clne_pkg::ROW1_BASE;  // row one and invalid rows
    endcase
  end

  always_comb begin
    entry = '0;
    unique case (clne_pkg::func_t'(in_func))
      clne_pkg::FUNC_INIT: begin
        entry.is_init = 1'b1;
      end
      clne_pkg::FUNC_PUT: begin
        unique case (in_char_code)
          clne_pkg::CHAR_FORMFEED:  entry.data = clne_pkg::CMD_CLEAR;
          clne_pkg::CHAR_NEWLINE:   entry.data = clne_pkg::CMD_LINE2;
          clne_pkg::CHAR_BACKSPACE: entry.data = clne_pkg::CMD_CURSOR_LEFT;
          default: begin
            entry.data = in_char_code;
            entry.rs   = 1'b1;
          end
        endcase
      end
      clne_pkg::FUNC_GOTO: begin
        // column counts from one; wraps mod 256
        entry.data = base + {2'b00, in_column} - 8'd1;
      end
      default: begin
        entry.data = in_char_code;
        entry.rs   = 1'b1;
      end
    endcase
  end

endmodule

// ===== rtl/clne_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clne_queue: request queue
// Small FIFO of classified requests between the front and the back.
// ----------------------------------------------------------------------------
module clne_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  clne_pkg::entry_t    push_entry,
  input  logic                pop,
  output logic                full,
  output clne_pkg::entry_t    head,
  output clne_pkg::q_status_t status
);

  clne_pkg::entry_t                  mem [clne_pkg::QUEUE_DEPTH];
  logic [clne_pkg::QPTR_W-1:0]       wr_ptr_r, wr_ptr_nxt;
  logic [clne_pkg::QPTR_W-1:0]       rd_ptr_r, rd_ptr_nxt;
  logic [clne_pkg::QCNT_W-1:0]       count_r, count_nxt;

  function automatic logic [clne_pkg::QPTR_W-1:0] ptr_inc(
    input logic [clne_pkg::QPTR_W-1:0] p
  );
    if (p == clne_pkg::QPTR_W'(clne_pkg::QUEUE_DEPTH - 1)) return '0;
    return p + 1'b1;
  endfunction

  always_comb begin
    wr_ptr_nxt = push ? ptr_inc(wr_ptr_r) : wr_ptr_r;
    rd_ptr_nxt = pop  ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) count_nxt = count_r + 1'b1;
    else if (!push && pop) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr_r] <= push_entry;
  end

  assign full              = (count_r == clne_pkg::QCNT_W'(clne_pkg::QUEUE_DEPTH));
  assign head              = mem[rd_ptr_r];
  assign status.head_valid = (count_r != '0);
  assign status.count      = count_r;

endmodule

// ===== rtl/clne_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clne_back: nibble sequencer
// Walks the head request one nibble write per cycle, while the output is not stalled, into the output register.
// ----------------------------------------------------------------------------
module clne_back (
  input  logic                   clk,
  input  logic                   rst_n,
  input  clne_pkg::cfg_t         cfg,
  input  logic                   head_valid,
  input  clne_pkg::entry_t       head,
  output logic                   pop,
  output clne_pkg::back_status_t status,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [3:0]             out_bus_nibble,
  output logic                   out_reg_select,
  output logic                   out_last_write
);

  logic [clne_pkg::STEP_W-1:0] step_r, step_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic [3:0]                  nib_r, nib_nxt;
  logic                        rs_r, rs_nxt;
  logic                        last_r, last_nxt;
  logic                        load, fire, at_last;
  logic [3:0]                  init_nib;

  always_comb begin
    unique case (step_r) inside
      4'd0, 4'd1, 4'd2: init_nib = clne_pkg::WAKE_NIB;
      4'd3:  init_nib = clne_pkg::MODE4_NIB;
      4'd4:  init_nib = cfg.function_set[7:4];
      4'd5:  init_nib = cfg.function_set[3:0];
      4'd6:  init_nib = cfg.display_ctrl[7:4];
      4'd7:  init_nib = cfg.display_ctrl[3:0];
      4'd8:  init_nib = clne_pkg::CMD_CLEAR[7:4];
      4'd9:  init_nib = clne_pkg::CMD_CLEAR[3:0];
      4'd10: init_nib = cfg.entry_mode[7:4];
      4'd11: init_nib = cfg.entry_mode[3:0];
      default: init_nib = 4'h0;
    endcase
  end

  always_comb begin
    load    = !out_valid_r || !out_stall;
    fire    = load && head_valid;
    at_last = (step_r == (head.is_init ? clne_pkg::INIT_LAST : clne_pkg::BYTE_LAST));
    pop     = fire && at_last;

    nib_nxt  = nib_r;
    rs_nxt   = rs_r;
    last_nxt = last_r;
    step_nxt = step_r;
    out_valid_nxt = load ? 1'b0 : out_valid_r;
    if (fire) begin
      out_valid_nxt = 1'b1;
      last_nxt      = at_last;
      rs_nxt        = head.rs;
      if (head.is_init) nib_nxt = init_nib;
      else nib_nxt = step_r[0] ? head.data[3:0] : head.data[7:4];
      step_nxt = at_last ? '0 : step_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      step_r      <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      step_r      <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    nib_r  <= nib_nxt;
    rs_r   <= rs_nxt;
    last_r <= last_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_bus_nibble = nib_r;
  assign out_reg_select = rs_r;
  assign out_last_write = last_r;
  assign status.fire    = fire;
  assign status.pop     = pop;
  assign status.step    = step_r;

endmodule

// ===== rtl/char_lcd_nibble_command_encoder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// char_lcd_nibble_command_encoder: character LCD 4-bit command encoder
// Turns init, put-character, goto and raw-data requests into nibble writes.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall): one request per transaction, kind in
//   in_func. Accepted when in_valid is high and in_stall is low.
//   Output channel (out_valid / out_stall): one nibble write per transaction,
//   high nibble first, with register select and a flag on the request's last
//   write.
//   Config port: cfg_we writes cfg_data[7:0] to register cfg_idx (0 function
//   set, 1 display control, 2 entry mode); index 3 is ignored. Write only
//   while idle.
//   Path: an accepted request is held in the queue, and its first nibble
//   then in the output register, before that nibble can be taken.
//   Throughput: one nibble write per cycle while out_stall is low, set by the back
//   sequencer; a byte request is two nibble writes, init is twelve.
//   A two-entry request queue decouples the classifier from the sequencer;
//   in_stall rises only when that queue is full.
//   Reset: queue empties, sequencer returns to step 0, registers take their
//   defaults (0x28, 0x0C, 0x06).
//   Output stall: the output register holds its transaction, the sequencer
//   pauses, and the queue keeps taking requests until full.
// ----------------------------------------------------------------------------
module char_lcd_nibble_command_encoder (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] in_func,
  input  logic [7:0] in_char_code,
  input  logic [5:0] in_column,
  input  logic [2:0] in_row,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [3:0] out_bus_nibble,
  output logic       out_reg_select,
  output logic       out_last_write,
  input  logic       cfg_we,
  input  logic [1:0] cfg_idx,
  input  logic [7:0] cfg_data
);

  clne_pkg::cfg_t         cfg_r, cfg_nxt;
  clne_pkg::entry_t       front_entry;
  clne_pkg::entry_t       head;
  clne_pkg::q_status_t    q_status;
  clne_pkg::back_status_t b_status;
  logic                   q_full;
  logic                   push;
  logic                   pop;

  // Configuration registers
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (clne_pkg::cfg_idx_t'(cfg_idx))
        clne_pkg::CFG_FUNCTION_SET: cfg_nxt.function_set = cfg_data;
        clne_pkg::CFG_DISPLAY_CTRL: cfg_nxt.display_ctrl = cfg_data;
        clne_pkg::CFG_ENTRY_MODE:   cfg_nxt.entry_mode   = cfg_data;
        default: ;  // unmapped index
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.function_set <= clne_pkg::FUNCTION_SET_RST;
      cfg_r.display_ctrl <= clne_pkg::DISPLAY_CTRL_RST;
      cfg_r.entry_mode   <= clne_pkg::ENTRY_MODE_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Front: classify the incoming request
  clne_front u_front (
    .in_func      (in_func),
    .in_char_code (in_char_code),
    .in_column    (in_column),
    .in_row       (in_row),
    .entry        (front_entry)
  );

  assign in_stall = q_full;
  assign push     = in_valid && !q_full;

  clne_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (front_entry),
    .pop        (pop),
    .full       (q_full),
    .head       (head),
    .status     (q_status)
  );

  // Back: sequence nibble writes from the queue head
  clne_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg_r),
    .head_valid     (q_status.head_valid),
    .head           (head),
    .pop            (pop),
    .status         (b_status),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_bus_nibble (out_bus_nibble),
    .out_reg_select (out_reg_select),
    .out_last_write (out_last_write)
  );

  // Assertions
  a_step_needs_head: assert property (@(posedge clk) disable iff (!rst_n)
    (b_status.step != '0) |-> q_status.head_valid)
    else $error("sequencer mid-request with empty queue");

  a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
    b_status.step <= clne_pkg::INIT_LAST)
    else $error("sequencer step out of range");

  a_pop_marks_last: assert property (@(posedge clk) disable iff (!rst_n)
    b_status.pop |=> (out_valid && out_last_write))
    else $error("queue pop without last-write flag on output");

  a_fire_gives_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (b_status.fire && !b_status.pop) |=> (out_valid && !out_last_write))
    else $error("mid-request write flagged as last");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_status.count <= clne_pkg::QCNT_W'(clne_pkg::QUEUE_DEPTH))
    else $error("queue count overflow");

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for char_lcd_nibble_command_encoder
// Drives init, put-character, goto and raw-data requests under several
// handshake idling phases and register settings. Each accepted request is
// turned into its expected nibble writes by a local predictor, and every
// accepted nibble write is checked field by field against the oldest one.
// ----------------------------------------------------------------------------

typedef struct packed {
  logic [3:0] nibble;
  logic       rs;
  logic       last;
} nibble_write_t;

class lcd_write_scoreboard;
  localparam logic [7:0] ASCII_FF = 8'h0C;
  localparam logic [7:0] ASCII_LF = 8'h0A;
  localparam logic [7:0] ASCII_BS = 8'h08;

  logic [7:0]    function_set;
  logic [7:0]    display_ctrl;
  logic [7:0]    entry_mode;
  nibble_write_t pending_writes[$];
  int            errors;

  function new();
    function_set = 8'h28;
    display_ctrl = 8'h0C;
    entry_mode   = 8'h06;
    errors       = 0;
  endfunction

  task report(string what);
    $display("[%0t] MISMATCH: %s", $realtime, what);
    errors++;
  endtask

  function void set_register(logic [1:0] idx, logic [7:0] value);
    case (idx)
      clne_pkg::CFG_FUNCTION_SET: function_set = value;
      clne_pkg::CFG_DISPLAY_CTRL: display_ctrl = value;
      clne_pkg::CFG_ENTRY_MODE:   entry_mode   = value;
      default: ;
    endcase
  endfunction

  function void push_nibble(logic [3:0] nib, logic rs);
    nibble_write_t w;
    w.nibble = nib;
    w.rs     = rs;
    w.last   = 1'b0;
    pending_writes.push_back(w);
  endfunction

  function void push_byte(logic [7:0] b, logic rs);
    push_nibble(b[7:4], rs);
    push_nibble(b[3:0], rs);
  endfunction

  // Expected writes for one accepted request
  function void note_request(clne_pkg::func_t f, logic [7:0] ch, logic [5:0] col,
                             logic [2:0] row);
    logic [7:0]    base;
    logic [7:0]    addr;
    nibble_write_t tail;
    case (f)
      clne_pkg::FUNC_INIT: begin
        push_nibble(4'h3, 1'b0);
        push_nibble(4'h3, 1'b0);
        push_nibble(4'h3, 1'b0);
        push_nibble(4'h2, 1'b0);
        push_byte(function_set, 1'b0);
        push_byte(display_ctrl, 1'b0);
        push_byte(8'h01, 1'b0);
        push_byte(entry_mode, 1'b0);
      end
      clne_pkg::FUNC_PUT: begin
        if (ch == ASCII_FF) push_byte(8'h01, 1'b0);
        else if (ch == ASCII_LF) push_byte(8'hC0, 1'b0);
        else if (ch == ASCII_BS) push_byte(8'h10, 1'b0);
        else push_byte(ch, 1'b1);
      end
      clne_pkg::FUNC_GOTO: begin
        case (row)
          3'd2:    base = 8'hC0;
          3'd3:    base = 8'h94;
          3'd4:    base = 8'hD4;
          default: base = 8'h80;
        endcase
        addr = base + {2'b00, col} - 8'd1;
        push_byte(addr, 1'b0);
      end
      default: push_byte(ch, 1'b1);
    endcase
    tail = pending_writes.pop_back();
    tail.last = 1'b1;
    pending_writes.push_back(tail);
  endfunction

  task check_write(logic [3:0] nib, logic rs, logic last);
    nibble_write_t w;
    if (pending_writes.size() == 0) begin
      report($sformatf("unexpected write nibble=%h rs=%b last=%b", nib, rs, last));
    end else begin
      w = pending_writes.pop_front();
      if (nib !== w.nibble)
        report($sformatf("bus_nibble got %h want %h", nib, w.nibble));
      if (rs !== w.rs)
        report($sformatf("reg_select got %b want %b", rs, w.rs));
      if (last !== w.last)
        report($sformatf("last_write got %b want %b", last, w.last));
    end
  endtask

  function int pending();
    return pending_writes.size();
  endfunction

  task close();
    if (pending_writes.size() != 0)
      report($sformatf("%0d expected writes never arrived", pending_writes.size()));
  endtask
endclass

module testbench;
  localparam int          HALF_PERIOD  = 6;
  localparam int          QUIET_LIMIT  = 2000;  // cycles with no transaction on either side
  localparam int          SETTLE_CYCLES = 4;    // settling margin after the last expected write
  localparam int          PHASE_ITEMS  = 20;
  localparam logic [1:0]  CFG_UNUSED_IDX = 2'd3;  // out of range, must be ignored

  localparam logic [7:0]  ASCII_FF = 8'h0C;
  localparam logic [7:0]  ASCII_LF = 8'h0A;
  localparam logic [7:0]  ASCII_BS = 8'h08;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  logic [1:0] in_func;
  logic [7:0] in_char_code;
  logic [5:0] in_column;
  logic [2:0] in_row;
  logic       out_valid;
  logic       out_stall;
  logic [3:0] out_bus_nibble;
  logic       out_reg_select;
  logic       out_last_write;
  logic       cfg_we;
  logic [1:0] cfg_idx;
  logic [7:0] cfg_data;

  // percent chance per cycle that the sender idles / the receiver stalls
  int send_idle_pct;
  int stall_pct;
  int quiet_cycles;

  lcd_write_scoreboard sb;

  char_lcd_nibble_command_encoder dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_func        (in_func),
    .in_char_code   (in_char_code),
    .in_column      (in_column),
    .in_row         (in_row),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_bus_nibble (out_bus_nibble),
    .out_reg_select (out_reg_select),
    .out_last_write (out_last_write),
    .cfg_we         (cfg_we),
    .cfg_idx        (cfg_idx),
    .cfg_data       (cfg_data)
  );

  always #HALF_PERIOD clk = ~clk;

  // Receiver: random stall per cycle, held low during reset
  always @(posedge clk) begin
    if (!rst_n) out_stall <= 1'b0;
    else out_stall <= ($urandom_range(99) < stall_pct);
  end

  // Monitor: sample both channels at the edge, before this edge's updates land
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall)
        sb.note_request(clne_pkg::func_t'(in_func), in_char_code, in_column, in_row);
      if (out_valid && !out_stall)
        sb.check_write(out_bus_nibble, out_reg_select, out_last_write);
    end
  end

  // Watchdog: a run of edges with no transaction at all means a hang
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Watchdog: no transaction for %0d cycles", QUIET_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // One request transaction. in_valid is left high on return so that a
  // back-to-back request never drops it within the same time step.
  task automatic send_request(clne_pkg::func_t f, logic [7:0] ch, logic [5:0] col,
                              logic [2:0] row);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_func      <= f;
    in_char_code <= ch;
    in_column    <= col;
    in_row       <= row;
    do @(posedge clk); while (in_stall);
  endtask

  // Random request; control characters are favored so put-character
  // commands show up often, unused fields always carry noise
  task automatic send_random_request();
    clne_pkg::func_t f;
    logic [7:0]      ch;
    f = clne_pkg::func_t'(2'($urandom_range(3)));
    case ($urandom_range(7))
      0:       ch = ASCII_FF;
      1:       ch = ASCII_LF;
      2:       ch = ASCII_BS;
      default: ch = 8'($urandom_range(255));
    endcase
    send_request(f, ch, 6'($urandom_range(63)), 3'($urandom_range(7)));
  endtask

  // Sender stops and waits until every expected write has come out
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // One register write. cfg_we is left high on return so that back-to-back
  // writes never drop it within the same time step; the caller lowers it.
  task automatic write_register(logic [1:0] idx, logic [7:0] value);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= value;
    @(posedge clk);
    sb.set_register(idx, value);
  endtask

  task automatic write_all(logic [7:0] fs, logic [7:0] dc, logic [7:0] em);
    write_register(clne_pkg::CFG_FUNCTION_SET, fs);
    write_register(clne_pkg::CFG_DISPLAY_CTRL, dc);
    write_register(clne_pkg::CFG_ENTRY_MODE, em);
  endtask

  task automatic random_phase(int idle_pct, int stall);
    send_idle_pct <= idle_pct;
    stall_pct     <= stall;
    write_all(8'($urandom_range(255)), 8'($urandom_range(255)), 8'($urandom_range(255)));
    cfg_we <= 1'b0;
    send_request(clne_pkg::FUNC_INIT, 8'($urandom_range(255)), 6'($urandom_range(63)),
                 3'($urandom_range(7)));
    repeat (PHASE_ITEMS) send_random_request();
    drain();
  endtask

  initial begin
    sb = new();
    rst_n         <= 1'b0;
    in_valid      <= 1'b0;
    in_func       <= clne_pkg::FUNC_INIT;
    in_char_code  <= 8'h00;
    in_column     <= 6'd0;
    in_row        <= 3'd0;
    cfg_we        <= 1'b0;
    cfg_idx       <= clne_pkg::CFG_FUNCTION_SET;
    cfg_data      <= 8'h00;
    send_idle_pct <= 0;
    stall_pct     <= 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part, no idling. Init first with the reset register values.
    send_request(clne_pkg::FUNC_INIT, 8'hFF, 6'h3F, 3'h7);
    // put character: the three control codes, then plain data
    send_request(clne_pkg::FUNC_PUT, ASCII_FF, 6'h00, 3'h0);
    send_request(clne_pkg::FUNC_PUT, ASCII_LF, 6'h3F, 3'h7);
    send_request(clne_pkg::FUNC_PUT, ASCII_BS, 6'h15, 3'h2);
    send_request(clne_pkg::FUNC_PUT, 8'h25, 6'h2A, 3'h5);   // '%' goes out as data
    send_request(clne_pkg::FUNC_PUT, 8'h00, 6'h3F, 3'h0);
    send_request(clne_pkg::FUNC_PUT, 8'hFF, 6'h00, 3'h7);
    // goto: each row base, column extremes, column 0 wraps below the base
    send_request(clne_pkg::FUNC_GOTO, 8'hFF, 6'd1, 3'd1);
    send_request(clne_pkg::FUNC_GOTO, 8'h00, 6'd40, 3'd2);
    send_request(clne_pkg::FUNC_GOTO, 8'hAA, 6'd20, 3'd3);
    send_request(clne_pkg::FUNC_GOTO, 8'h55, 6'd63, 3'd4);
    // rows outside one..four fall back to the first row base
    send_request(clne_pkg::FUNC_GOTO, 8'h0C, 6'd0, 3'd0);
    send_request(clne_pkg::FUNC_GOTO, 8'h0A, 6'd1, 3'd5);
    send_request(clne_pkg::FUNC_GOTO, 8'h08, 6'd7, 3'd6);
    send_request(clne_pkg::FUNC_GOTO, 8'hFF, 6'd40, 3'd7);
    // raw data: control codes are not translated here
    send_request(clne_pkg::FUNC_RAW, 8'h00, 6'h3F, 3'h7);
    send_request(clne_pkg::FUNC_RAW, 8'hFF, 6'h00, 3'h0);
    send_request(clne_pkg::FUNC_RAW, ASCII_FF, 6'h2A, 3'h3);
    drain();

    // Register extremes, plus a write to the unused index that must not land
    write_all(8'h00, 8'h00, 8'h00);
    write_register(CFG_UNUSED_IDX, 8'hFF);
    cfg_we <= 1'b0;
    send_request(clne_pkg::FUNC_INIT, 8'h00, 6'h00, 3'h0);
    drain();
    write_all(8'hFF, 8'hFF, 8'hFF);
    write_register(CFG_UNUSED_IDX, 8'h00);
    cfg_we <= 1'b0;
    send_request(clne_pkg::FUNC_INIT, 8'h00, 6'h00, 3'h0);
    drain();

    // Random part over the idling phases; each phase drains before the
    // next register change
    random_phase(0, 0);
    random_phase(69, 0);
    random_phase(0, 69);
    random_phase(10, 10);

    sb.close();
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule
